[design/dual_gain_peak_auto_select_unit_macros.svh]
// Assertion macros used by the back end of the dual-gain peak selection unit.
`ifndef DUAL_GAIN_PEAK_AUTO_SELECT_UNIT_MACROS_SVH
`define DUAL_GAIN_PEAK_AUTO_SELECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DGP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DGP_ASSERT_NOW(label, ante, cons, msg)
`define DGP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/dgp_pkg.sv]
// Types and constants of the dual-gain peak selection unit.
`default_nettype none
package dgp_pkg;
    localparam int ADC_BITS    = 10;
    localparam int NUM_MODULES = 4;
    localparam int NUM_SLOTS   = 4;
    localparam int MOD_W       = 2;
    localparam int SLOPE_W     = 16;
    localparam int OFFSET_W    = 16;
    localparam int PROD_W      = SLOPE_W + ADC_BITS;
    localparam int ROUND_SHIFT = 4;
    localparam int ROUND_HALF  = 8;
    localparam int LOW_SHIFT   = 12;
    localparam int ENERGY_W    = 23;
    localparam int SUM_W       = 25;
    localparam int ACC_W       = 12;
    localparam int Q_W         = 3;
    localparam int ENERGY_MAX  = 4194303;
    localparam int SUM_MAX     = 16777215;
    localparam int SUM_MIN     = -16777216;
    localparam int ACC_MAX     = 4095;

    localparam logic [Q_W-1:0] FLAG_SAT = 3'h1;
    localparam logic [Q_W-1:0] FLAG_PLO = 3'h2;
    localparam logic [Q_W-1:0] FLAG_PHI = 3'h4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_C   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_C   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PED_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PED_MAX = 3'd7;
    localparam logic [ADC_BITS-1:0] PED_MIN_RESET = 10'd10;
    localparam logic [ADC_BITS-1:0] PED_MAX_RESET = 10'd160;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic                side;
        logic [MOD_W-1:0]    module_req;
        logic [ADC_BITS-1:0] peak_low;
        logic [ADC_BITS-1:0] peak_high;
        logic [ADC_BITS-1:0] ped_high;
        logic                last_module;
    } meas_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][ADC_BITS-1:0] sat_a;
        logic [NUM_SLOTS-1:0][ADC_BITS-1:0] sat_c;
        logic [NUM_SLOTS-1:0][SLOPE_W-1:0]  slope_a;
        logic [NUM_SLOTS-1:0][SLOPE_W-1:0]  slope_c;
        logic [NUM_SLOTS-1:0][OFFSET_W-1:0] off_a;
        logic [NUM_SLOTS-1:0][OFFSET_W-1:0] off_c;
        logic [ADC_BITS-1:0]                ped_min;
        logic [ADC_BITS-1:0]                ped_max;
    } cfg_t;
endpackage
`default_nettype wire

[design/dgp_front.sv]
// Front end: pedestal capture and running maxima, one measurement per waveform.
`default_nettype none
module dgp_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic                         side,
    input  wire logic [dgp_pkg::MOD_W-1:0]    module_req,
    input  wire logic [dgp_pkg::ADC_BITS-1:0] sample_low,
    input  wire logic [dgp_pkg::ADC_BITS-1:0] sample_high,
    input  wire logic                         last_sample,
    input  wire logic                         last_module,
    output logic                              push,
    output dgp_pkg::meas_t                    push_data
);
    logic                         accept;
    logic                         expect_ped_reg, expect_ped_next;
    logic [dgp_pkg::ADC_BITS-1:0] ped_low_reg, ped_low_next;
    logic [dgp_pkg::ADC_BITS-1:0] ped_high_reg, ped_high_next;
    logic [dgp_pkg::ADC_BITS-1:0] max_low_reg, max_low_next;
    logic [dgp_pkg::ADC_BITS-1:0] max_high_reg, max_high_next;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (expect_ped_reg)
        begin
            ped_low_next  = sample_low;
            ped_high_next = sample_high;
            max_low_next  = sample_low;
            max_high_next = sample_high;
        end
        else
        begin
            ped_low_next  = ped_low_reg;
            ped_high_next = ped_high_reg;
            max_low_next  = (sample_low > max_low_reg) ? sample_low : max_low_reg;
            max_high_next = (sample_high > max_high_reg) ? sample_high : max_high_reg;
        end
        expect_ped_next = last_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_ped_reg <= 1'b1;
            ped_low_reg    <= '0;
            ped_high_reg   <= '0;
            max_low_reg    <= '0;
            max_high_reg   <= '0;
        end
        else if (accept)
        begin
            expect_ped_reg <= expect_ped_next;
            ped_low_reg    <= ped_low_next;
            ped_high_reg   <= ped_high_next;
            max_low_reg    <= max_low_next;
            max_high_reg   <= max_high_next;
        end
    end

    assign push                  = accept && last_sample;
    assign push_data.side        = side;
    assign push_data.module_req  = module_req;
    assign push_data.peak_low    = max_low_next - ped_low_next;
    assign push_data.peak_high   = max_high_next - ped_high_next;
    assign push_data.ped_high    = ped_high_next;
    assign push_data.last_module = last_module;
endmodule
`default_nettype wire

[design/dgp_fifo.sv]
// Short register queue of measurements between the front and back ends.
`default_nettype none
module dgp_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dgp_pkg::meas_t push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output dgp_pkg::meas_t      head_data
);
    dgp_pkg::meas_t             entries [dgp_pkg::QUEUE_DEPTH];
    logic [dgp_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dgp_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == dgp_pkg::QCNT_W'(dgp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[design/dgp_back.sv]
// Back end: quality flags, gain conversion, energy clamp and running sums.
`default_nettype none
`include "dual_gain_peak_auto_select_unit_macros.svh"
module dgp_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dgp_pkg::cfg_t                cfg,
    input  wire logic                         head_valid,
    input  wire dgp_pkg::meas_t               head_data,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              out_side,
    output logic [dgp_pkg::MOD_W-1:0]         out_module,
    output logic [dgp_pkg::ADC_BITS-1:0]      peak_low_gain,
    output logic [dgp_pkg::ADC_BITS-1:0]      peak_high_gain,
    output logic [dgp_pkg::Q_W-1:0]           quality,
    output logic signed [dgp_pkg::ENERGY_W-1:0] module_energy,
    output logic signed [dgp_pkg::SUM_W-1:0]  energy_sum,
    output logic [dgp_pkg::ACC_W-1:0]         low_gain_sum,
    output logic [dgp_pkg::ACC_W-1:0]         high_gain_sum,
    output logic                              event_last
);
    // Stage one: flags and product.
    logic [dgp_pkg::MOD_W-1:0]    slot;
    logic [dgp_pkg::ADC_BITS-1:0] limit;
    logic [dgp_pkg::SLOPE_W-1:0]  slope;
    logic [dgp_pkg::OFFSET_W-1:0] offset;
    logic [dgp_pkg::Q_W-1:0]      q_s0;
    logic [dgp_pkg::PROD_W-1:0]   prod_s0;

    logic                         s1_valid_reg;
    logic                         s1_side_reg, s1_last_reg;
    logic [dgp_pkg::MOD_W-1:0]    s1_mod_reg;
    logic [dgp_pkg::ADC_BITS-1:0] s1_plo_reg, s1_phi_reg;
    logic [dgp_pkg::Q_W-1:0]      s1_q_reg;
    logic [dgp_pkg::PROD_W-1:0]   s1_prod_reg;
    logic signed [dgp_pkg::OFFSET_W-1:0] s1_off_reg;

    // Stage two: selected and clamped energy.
    logic [dgp_pkg::PROD_W:0]             rounded;
    logic signed [dgp_pkg::ENERGY_W:0]    hg_energy;
    logic signed [dgp_pkg::ENERGY_W-1:0]  energy_s1;

    logic                         s2_valid_reg;
    logic                         s2_side_reg, s2_last_reg;
    logic [dgp_pkg::MOD_W-1:0]    s2_mod_reg;
    logic [dgp_pkg::ADC_BITS-1:0] s2_plo_reg, s2_phi_reg;
    logic [dgp_pkg::Q_W-1:0]      s2_q_reg;
    logic signed [dgp_pkg::ENERGY_W-1:0] s2_energy_reg;

    // Output stage and event sums.
    logic signed [dgp_pkg::SUM_W:0]   esum_raw;
    logic signed [dgp_pkg::SUM_W-1:0] esum_next;
    logic [dgp_pkg::ACC_W:0]          lsum_raw, hsum_raw;
    logic [dgp_pkg::ACC_W-1:0]        lsum_next, hsum_next;
    logic signed [dgp_pkg::SUM_W-1:0] energy_acc_reg, energy_acc_next;
    logic [dgp_pkg::ACC_W-1:0]        low_acc_reg, low_acc_next;
    logic [dgp_pkg::ACC_W-1:0]        high_acc_reg, high_acc_next;

    logic out_valid_reg;
    logic out_load, s2_en, s1_en;

    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_en    = !s2_valid_reg || out_load;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign pop      = head_valid && s1_en;

    always_comb
    begin
        if (head_data.module_req >= dgp_pkg::MOD_W'(dgp_pkg::NUM_MODULES - 1))
        begin
            slot = dgp_pkg::MOD_W'(dgp_pkg::NUM_MODULES - 1);
        end
        else
        begin
            slot = head_data.module_req;
        end
        limit  = head_data.side ? cfg.sat_c[slot]   : cfg.sat_a[slot];
        slope  = head_data.side ? cfg.slope_c[slot] : cfg.slope_a[slot];
        offset = head_data.side ? cfg.off_c[slot]   : cfg.off_a[slot];
        q_s0   = '0;
        if (head_data.peak_high > limit)
        begin
            q_s0 = q_s0 | dgp_pkg::FLAG_SAT;
        end
        if (head_data.ped_high < cfg.ped_min)
        begin
            q_s0 = q_s0 | dgp_pkg::FLAG_PLO;
        end
        if (head_data.ped_high > cfg.ped_max)
        begin
            q_s0 = q_s0 | dgp_pkg::FLAG_PHI;
        end
        prod_s0 = dgp_pkg::PROD_W'(slope) * dgp_pkg::PROD_W'(head_data.peak_high);
    end

    always_comb
    begin
        rounded   = (dgp_pkg::PROD_W + 1)'(s1_prod_reg)
                    + (dgp_pkg::PROD_W + 1)'(dgp_pkg::ROUND_HALF);
        hg_energy = $signed({1'b0, rounded[dgp_pkg::ROUND_SHIFT +: dgp_pkg::ENERGY_W]})
                    + (dgp_pkg::ENERGY_W + 1)'(s1_off_reg);
        if (s1_q_reg != '0)
        begin
            energy_s1 = $signed(dgp_pkg::ENERGY_W'({s1_plo_reg, {dgp_pkg::LOW_SHIFT{1'b0}}}));
        end
        else if (hg_energy > (dgp_pkg::ENERGY_W + 1)'(dgp_pkg::ENERGY_MAX))
        begin
            energy_s1 = dgp_pkg::ENERGY_W'(dgp_pkg::ENERGY_MAX);
        end
        else
        begin
            energy_s1 = hg_energy[dgp_pkg::ENERGY_W-1:0];
        end
    end

    always_comb
    begin
        esum_raw = (dgp_pkg::SUM_W + 1)'(energy_acc_reg)
                   + (dgp_pkg::SUM_W + 1)'(s2_energy_reg);
        if (esum_raw > (dgp_pkg::SUM_W + 1)'(dgp_pkg::SUM_MAX))
        begin
            esum_next = dgp_pkg::SUM_W'(dgp_pkg::SUM_MAX);
        end
        else if (esum_raw < (dgp_pkg::SUM_W + 1)'(dgp_pkg::SUM_MIN))
        begin
            esum_next = dgp_pkg::SUM_W'(dgp_pkg::SUM_MIN);
        end
        else
        begin
            esum_next = esum_raw[dgp_pkg::SUM_W-1:0];
        end
        lsum_raw  = (dgp_pkg::ACC_W + 1)'(low_acc_reg) + (dgp_pkg::ACC_W + 1)'(s2_plo_reg);
        hsum_raw  = (dgp_pkg::ACC_W + 1)'(high_acc_reg) + (dgp_pkg::ACC_W + 1)'(s2_phi_reg);
        lsum_next = lsum_raw[dgp_pkg::ACC_W] ? dgp_pkg::ACC_W'(dgp_pkg::ACC_MAX)
                                             : lsum_raw[dgp_pkg::ACC_W-1:0];
        hsum_next = hsum_raw[dgp_pkg::ACC_W] ? dgp_pkg::ACC_W'(dgp_pkg::ACC_MAX)
                                             : hsum_raw[dgp_pkg::ACC_W-1:0];
        if (s2_last_reg)
        begin
            energy_acc_next = '0;
            low_acc_next    = '0;
            high_acc_next   = '0;
        end
        else
        begin
            energy_acc_next = esum_next;
            low_acc_next    = lsum_next;
            high_acc_next   = hsum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            energy_acc_reg <= '0;
            low_acc_reg    <= '0;
            high_acc_reg   <= '0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= head_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                energy_acc_reg <= energy_acc_next;
                low_acc_reg    <= low_acc_next;
                high_acc_reg   <= high_acc_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_side_reg <= head_data.side;
            s1_mod_reg  <= head_data.module_req;
            s1_plo_reg  <= head_data.peak_low;
            s1_phi_reg  <= head_data.peak_high;
            s1_q_reg    <= q_s0;
            s1_prod_reg <= prod_s0;
            s1_off_reg  <= $signed(offset);
            s1_last_reg <= head_data.last_module;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_side_reg   <= s1_side_reg;
            s2_mod_reg    <= s1_mod_reg;
            s2_plo_reg    <= s1_plo_reg;
            s2_phi_reg    <= s1_phi_reg;
            s2_q_reg      <= s1_q_reg;
            s2_energy_reg <= energy_s1;
            s2_last_reg   <= s1_last_reg;
        end
        if (out_load)
        begin
            out_side       <= s2_side_reg;
            out_module     <= s2_mod_reg;
            peak_low_gain  <= s2_plo_reg;
            peak_high_gain <= s2_phi_reg;
            quality        <= s2_q_reg;
            module_energy  <= s2_energy_reg;
            energy_sum     <= esum_next;
            low_gain_sum   <= lsum_next;
            high_gain_sum  <= hsum_next;
            event_last     <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;

    function automatic logic [dgp_pkg::ACC_W-1:0] ACC_W_EXT(
        input logic [dgp_pkg::ADC_BITS-1:0] v
    );
        return dgp_pkg::ACC_W'(v);
    endfunction

    `DGP_ASSERT_NEXT(a_sums_cleared, out_load && s2_last_reg,
        energy_acc_reg == '0 && low_acc_reg == '0 && high_acc_reg == '0,
        "event sums not cleared after the last module")
    `DGP_ASSERT_NOW(a_sums_cover_peaks, out_valid_reg,
        low_gain_sum >= ACC_W_EXT(peak_low_gain) && high_gain_sum >= ACC_W_EXT(peak_high_gain),
        "running sum below the peak it includes")
    `DGP_ASSERT_NOW(a_low_path_positive, out_valid_reg && quality != '0,
        !module_energy[dgp_pkg::ENERGY_W-1],
        "low-gain energy negative")
endmodule
`default_nettype wire

[design/dual_gain_peak_auto_select_unit.sv]
// A tlast word's measurement passes the queue, s1, s2 and output registers to m_tdata.
// Unstalled: one sample word per cycle in; the back pipeline retires one result per cycle.
// The four-entry queue between front and back absorbs output stalls before s_tready drops.
// Reset: rst_n is asynchronous and active low; it empties the queue and pipeline, clears the
// event sums and restores the configuration registers to their reset values.
`default_nettype none
module dual_gain_peak_auto_select_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [dgp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dgp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // module_req[1:0], sample_low_gain[11:2], sample_high_gain[21:12], zero fill
    input  wire logic [23:0]                      s_tdata,
    // side[0], last_module[1]
    input  wire logic [1:0]                       s_tuser,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_module[1:0], peak_low_gain[11:2], peak_high_gain[21:12], quality[24:22],
    // module_energy[47:25], energy_sum[72:48], low_gain_sum[84:73],
    // high_gain_sum[96:85], zero fill
    output logic [103:0]                          m_tdata,
    // out_side[0]
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    dgp_pkg::cfg_t  cfg_reg;
    dgp_pkg::meas_t push_data, head_data;
    logic           push, pop, full, head_valid;

    logic [dgp_pkg::MOD_W-1:0]           out_module;
    logic [dgp_pkg::ADC_BITS-1:0]        peak_low_gain, peak_high_gain;
    logic [dgp_pkg::Q_W-1:0]             quality;
    logic signed [dgp_pkg::ENERGY_W-1:0] module_energy;
    logic signed [dgp_pkg::SUM_W-1:0]    energy_sum;
    logic [dgp_pkg::ACC_W-1:0]           low_gain_sum, high_gain_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sat_a   <= '0;
            cfg_reg.sat_c   <= '0;
            cfg_reg.slope_a <= '0;
            cfg_reg.slope_c <= '0;
            cfg_reg.off_a   <= '0;
            cfg_reg.off_c   <= '0;
            cfg_reg.ped_min <= dgp_pkg::PED_MIN_RESET;
            cfg_reg.ped_max <= dgp_pkg::PED_MAX_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                dgp_pkg::CFG_SAT_A:   cfg_reg.sat_a   <= cfg_data[39:0];
                dgp_pkg::CFG_SAT_C:   cfg_reg.sat_c   <= cfg_data[39:0];
                dgp_pkg::CFG_SLOPE_A: cfg_reg.slope_a <= cfg_data;
                dgp_pkg::CFG_SLOPE_C: cfg_reg.slope_c <= cfg_data;
                dgp_pkg::CFG_OFF_A:   cfg_reg.off_a   <= cfg_data;
                dgp_pkg::CFG_OFF_C:   cfg_reg.off_c   <= cfg_data;
                dgp_pkg::CFG_PED_MIN: cfg_reg.ped_min <= cfg_data[dgp_pkg::ADC_BITS-1:0];
                dgp_pkg::CFG_PED_MAX: cfg_reg.ped_max <= cfg_data[dgp_pkg::ADC_BITS-1:0];
            endcase
        end
    end

    assign s_tready = !full;

    dgp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .side        (s_tuser[0]),
        .module_req  (s_tdata[1:0]),
        .sample_low  (s_tdata[11:2]),
        .sample_high (s_tdata[21:12]),
        .last_sample (s_tlast),
        .last_module (s_tuser[1]),
        .push        (push),
        .push_data   (push_data)
    );

    dgp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    dgp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head_valid     (head_valid),
        .head_data      (head_data),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_side       (m_tuser),
        .out_module     (out_module),
        .peak_low_gain  (peak_low_gain),
        .peak_high_gain (peak_high_gain),
        .quality        (quality),
        .module_energy  (module_energy),
        .energy_sum     (energy_sum),
        .low_gain_sum   (low_gain_sum),
        .high_gain_sum  (high_gain_sum),
        .event_last     (m_tlast)
    );

    assign m_tdata = {7'b0, high_gain_sum, low_gain_sum, energy_sum, module_energy,
                      quality, peak_high_gain, peak_low_gain, out_module};
endmodule
`default_nettype wire
